// File: design/suffix_array_match_finder_top_defines.svh
// Assertion macros of the match finder, used by samf_back.
// Depends on nothing; included by the modules that assert.
`ifndef SUFFIX_ARRAY_MATCH_FINDER_TOP_DEFINES_SVH
`define SUFFIX_ARRAY_MATCH_FINDER_TOP_DEFINES_SVH

// Check a property on every rising clock edge outside reset.
`define SAMF_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define SAMF_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

// File: design/samf_pkg.sv
// Shared types and constants of the suffix array match finder.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package samf_pkg;

  localparam int unsigned TextDepthDef  = 4096;
  localparam int unsigned MaxRepeatsDef = 3;

  localparam int unsigned FieldW = 12;
  localparam int unsigned CfgW   = 13;
  localparam int unsigned IdxW   = 3;

  localparam logic [CfgW-1:0] TotalLengthRst = 13'd4096;

  localparam logic [IdxW-1:0] RegRegionA   = 3'd0;
  localparam logic [IdxW-1:0] RegRegionB   = 3'd1;
  localparam logic [IdxW-1:0] RegRegionC   = 3'd2;
  localparam logic [IdxW-1:0] RegMirror    = 3'd3;
  localparam logic [IdxW-1:0] RegTotalLen  = 3'd4;
  localparam logic [IdxW-1:0] RegInPlace   = 3'd5;

  localparam logic ActLoad  = 1'b0;
  localparam logic ActQuery = 1'b1;

  localparam logic [1:0] KindA = 2'd0;
  localparam logic [1:0] KindB = 2'd1;
  localparam logic [1:0] KindC = 2'd2;
  localparam logic [1:0] KindD = 2'd3;

  typedef struct packed {
    logic              action;
    logic [FieldW-1:0] entry_addr;
    logic [FieldW-1:0] suffix_pos;
    logic [FieldW-1:0] rank_value;
    logic [FieldW-1:0] lcp_value;
    logic [FieldW-1:0] query_pos;
  } item_t;

  typedef struct packed {
    logic [CfgW-1:0] region_a;
    logic [CfgW-1:0] region_b;
    logic [CfgW-1:0] region_c;
    logic [CfgW-1:0] mirror;
    logic [CfgW-1:0] total_len;
    logic            in_place;
  } cfg_t;

  typedef struct packed {
    logic  empty;
    item_t head;
  } queue_stat_t;

endpackage

`default_nettype wire

// File: design/samf_ram.sv
// Generic single write port, single read port RAM with registered read.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module samf_ram #(
  parameter int unsigned Width = 12,
  parameter int unsigned Depth = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: design/samf_front.sv
// Front end: accepts words and holds them in a two entry queue.
// Depends on samf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module samf_front (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start,
  input  wire samf_pkg::item_t       item_i,
  input  wire logic                  pop_i,
  output logic                       busy,
  output samf_pkg::queue_stat_t      stat_o
);
  import samf_pkg::*;

  item_t      slot_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       push;

  assign busy   = (cnt_q == 2'd2);
  assign push   = start && !busy;
  assign stat_o = '{empty: (cnt_q == 2'd0), head: slot_q[rptr_q]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) begin
        slot_q[wptr_q] <= item_i;
        wptr_q         <= !wptr_q;
      end
      if (pop_i) begin
        rptr_q <= !rptr_q;
      end
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop_i};
    end
  end

endmodule

`default_nettype wire

// File: design/samf_back.sv
// Back end: writes table entries and runs the neighbour scan of a query.
// Depends on samf_pkg, samf_ram and the shared assertion macros.
`timescale 1ns / 1ps
`default_nettype none

module samf_back #(
  parameter int unsigned TextDepth  = samf_pkg::TextDepthDef,
  parameter int unsigned MaxRepeats = samf_pkg::MaxRepeatsDef
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire samf_pkg::cfg_t        cfg_i,
  input  wire samf_pkg::queue_stat_t stat_i,
  output logic                       pop_o,
  output logic                       result_valid_o,
  output logic [12:0]                match_start_o,
  output logic [31:0]                match_ref_o,
  output logic [11:0]                match_length_o,
  output logic [1:0]                 match_kind_o
);
  import samf_pkg::*;

  localparam int unsigned AW = $clog2(TextDepth);
  localparam int unsigned RW = $clog2(MaxRepeats + 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_RANK, ST_RGET, ST_CHECK, ST_DATA, ST_CALC, ST_CLASS, ST_OUT
  } state_e;

  state_e            st_q;
  logic              side_q;
  logic [31:0]       idx_q, off_q, m_q, k_q;
  logic [FieldW-1:0] q_q, r_q, run_q, prev_q, t_q, s_q;
  logic [RW-1:0]     reps_q;
  logic [FieldW-1:0] llen_q, lpos_q;
  logic [1:0]        lkind_q;
  logic [FieldW-1:0] rlen_q, rpos_q;
  logic [1:0]        rkind_q;

  logic              we;
  logic [AW-1:0]     waddr, rank_ra, lcp_ra, suf_ra;
  logic [FieldW-1:0] rank_rd, lcp_rd, suf_rd;

  logic [31:0]       nb_l, nb_r, nb_l1, tl_m1, a32, b32, c32, mp32, z;
  logic              stop_bnd, stop;
  logic [FieldW-1:0] run_n;
  logic              hit0, hit1, hit2, hit3;
  logic              end_v;
  logic [FieldW-1:0] end_len, end_pos;
  logic [1:0]        end_kind;
  logic              use_l;
  logic [FieldW-1:0] o_len, o_pos;
  logic [1:0]        o_kind;
  logic [31:0]       pl, ref_v;

  assign we    = (st_q == ST_IDLE) && !stat_i.empty && (stat_i.head.action == ActLoad);
  assign pop_o = (st_q == ST_IDLE) && !stat_i.empty;
  assign waddr = AW'(stat_i.head.entry_addr);

  assign a32   = {19'd0, cfg_i.region_a};
  assign b32   = {19'd0, cfg_i.region_b};
  assign c32   = {19'd0, cfg_i.region_c};
  assign mp32  = {19'd0, cfg_i.mirror};
  assign tl_m1 = {19'd0, cfg_i.total_len} - 32'd1;

  assign nb_l  = {20'd0, r_q} - off_q;
  assign nb_r  = {20'd0, r_q} + off_q;
  assign nb_l1 = nb_l + 32'd1;

  assign rank_ra = idx_q[AW-1:0];
  assign suf_ra  = side_q ? nb_r[AW-1:0] : nb_l[AW-1:0];
  assign lcp_ra  = side_q ? nb_r[AW-1:0] : nb_l1[AW-1:0];

  assign stop_bnd = side_q ? (nb_r > tl_m1)
                           : ({21'd0, r_q} < ({1'b0, a32} + {1'b0, off_q}));
  assign stop     = stop_bnd || (reps_q >= RW'(MaxRepeats));
  assign run_n    = (lcp_rd < run_q) ? lcp_rd : run_q;

  assign z    = mp32 - (k_q - mp32 + 32'd1);
  assign hit0 = ({20'd0, s_q} >= a32) && (m_q < b32) &&
                (!cfg_i.in_place || ((b32 - m_q) >= ({19'd0, cfg_i.total_len} - k_q)));
  assign hit1 = ({20'd0, s_q} >= b32) && (m_q < c32) &&
                (!cfg_i.in_place || (({20'd0, s_q} - b32) >= {20'd0, q_q}));
  assign hit2 = k_q < {20'd0, s_q};
  assign hit3 = ({20'd0, s_q} >= c32) && (m_q < z);

  always_comb begin
    end_v    = 1'b0;
    end_len  = '0;
    end_pos  = '0;
    end_kind = KindA;
    unique case (st_q)
      ST_CHECK: end_v = stop;
      ST_DATA:  end_v = (run_n == '0);
      ST_CLASS: begin
        end_v   = hit0 || hit1 || hit2 || hit3;
        end_len = t_q;
        end_pos = s_q;
        if (hit0) begin
          end_kind = KindA;
        end else if (hit1) begin
          end_kind = KindB;
        end else if (hit2) begin
          end_kind = KindC;
        end else begin
          end_kind = KindD;
        end
      end
      default: end_v = 1'b0;
    endcase
  end

  assign use_l  = llen_q >= rlen_q;
  assign o_len  = use_l ? llen_q : rlen_q;
  assign o_pos  = use_l ? lpos_q : rpos_q;
  assign o_kind = use_l ? lkind_q : rkind_q;
  assign pl     = {20'd0, o_pos} + {20'd0, o_len};

  always_comb begin
    case (o_kind)
      KindA:   ref_v = b32 - pl;
      KindB:   ref_v = pl - 32'd1 - b32;
      KindC:   ref_v = {19'd0, cfg_i.total_len} - pl;
      default: ref_v = pl - 32'd1 - c32;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q           <= ST_IDLE;
      side_q         <= 1'b0;
      idx_q          <= '0;
      q_q            <= '0;
      r_q            <= '0;
      off_q          <= 32'd1;
      run_q          <= '1;
      prev_q         <= '0;
      reps_q         <= '0;
      t_q            <= '0;
      s_q            <= '0;
      m_q            <= '0;
      k_q            <= '0;
      llen_q         <= '0;
      lpos_q         <= '0;
      lkind_q        <= KindA;
      rlen_q         <= '0;
      rpos_q         <= '0;
      rkind_q        <= KindA;
      result_valid_o <= 1'b0;
      match_start_o  <= '0;
      match_ref_o    <= '0;
      match_length_o <= '0;
      match_kind_o   <= KindA;
    end else begin
      result_valid_o <= 1'b0;
      unique case (st_q)
        ST_IDLE: begin
          if (pop_o && stat_i.head.action == ActQuery) begin
            q_q   <= stat_i.head.query_pos;
            idx_q <= {19'd0, cfg_i.total_len} - {20'd0, stat_i.head.query_pos} - 32'd1;
            st_q  <= ST_RANK;
          end
        end
        ST_RANK: st_q <= ST_RGET;
        ST_RGET: begin
          r_q    <= rank_rd;
          side_q <= 1'b0;
          off_q  <= 32'd1;
          run_q  <= '1;
          prev_q <= '0;
          reps_q <= '0;
          st_q   <= ST_CHECK;
        end
        ST_CHECK: begin
          if (!stop) begin
            st_q <= ST_DATA;
          end
        end
        ST_DATA: begin
          run_q  <= run_n;
          t_q    <= run_n;
          prev_q <= run_n;
          s_q    <= suf_rd;
          reps_q <= (run_n == prev_q) ? reps_q + RW'(1) : RW'(1);
          if (run_n != '0) begin
            st_q <= ST_CALC;
          end
        end
        ST_CALC: begin
          m_q  <= {20'd0, s_q} + {20'd0, t_q} - 32'd1;
          k_q  <= idx_q + {20'd0, t_q} - 32'd1;
          st_q <= ST_CLASS;
        end
        ST_CLASS: begin
          if (!end_v) begin
            off_q <= off_q + 32'd1;
            st_q  <= ST_CHECK;
          end
        end
        ST_OUT: begin
          result_valid_o <= 1'b1;
          match_length_o <= o_len;
          if (o_len == '0) begin
            match_start_o <= 13'({1'b0, q_q} + 13'd1);
            match_ref_o   <= '0;
            match_kind_o  <= KindA;
          end else begin
            match_start_o <= 13'({1'b0, q_q} - {1'b0, o_len} + 13'd1);
            match_ref_o   <= ref_v;
            match_kind_o  <= o_kind;
          end
          st_q <= ST_IDLE;
        end
        default: st_q <= ST_IDLE;
      endcase
      if (end_v) begin
        if (!side_q) begin
          llen_q  <= end_len;
          lpos_q  <= end_pos;
          lkind_q <= end_kind;
          side_q  <= 1'b1;
          off_q   <= 32'd1;
          run_q   <= '1;
          prev_q  <= '0;
          reps_q  <= '0;
          st_q    <= ST_CHECK;
        end else begin
          rlen_q  <= end_len;
          rpos_q  <= end_pos;
          rkind_q <= end_kind;
          st_q    <= ST_OUT;
        end
      end
    end
  end

  samf_ram #(.Width(FieldW), .Depth(TextDepth)) u_suffix (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(stat_i.head.suffix_pos),
    .raddr_i(suf_ra), .rdata_o(suf_rd)
  );
  samf_ram #(.Width(FieldW), .Depth(TextDepth)) u_rank (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(stat_i.head.rank_value),
    .raddr_i(rank_ra), .rdata_o(rank_rd)
  );
  samf_ram #(.Width(FieldW), .Depth(TextDepth)) u_lcp (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(stat_i.head.lcp_value),
    .raddr_i(lcp_ra), .rdata_o(lcp_rd)
  );

`include "suffix_array_match_finder_top_defines.svh"

`SAMF_ASSERT(a_nomatch_zero, clk_i, rst_ni, (result_valid_o && match_length_o == '0) |-> (match_ref_o == '0 && match_kind_o == KindA), "empty match carries data")
`SAMF_ASSERT(a_strobe_gap, clk_i, rst_ni, result_valid_o |=> !result_valid_o, "result strobes back to back")
`SAMF_NEVER(a_write_in_scan, clk_i, rst_ni, we && st_q != ST_IDLE, "table write during a scan")
`SAMF_ASSERT(a_out_follows, clk_i, rst_ni, result_valid_o |-> $past(st_q == ST_OUT), "strobe without output step")

endmodule

`default_nettype wire

// File: design/suffix_array_match_finder_top.sv
// Top level of the suffix array match finder: configuration registers,
// front queue and back end. Depends on samf_pkg, samf_front and samf_back.
//
// Usage:
//   Input channel: an item is taken at a rising edge with start high and
//   busy low. action 0 loads one entry of the suffix, rank and LCP tables
//   at entry_addr; action 1 queries query_pos.
//   A two word queue sits between the input and the back end, so busy rises
//   only when two words wait behind the word in progress.
//   A load is written from the back end's idle state and gives no result.
//   A query steps through setup (pop, rank address, rank read), then per
//   side through the check, data, calc and classify states for each neighbour
//   that reaches classification; a side stops in the check state on a bound
//   or on repeats, and in the data state on a zero length. An output state
//   follows; the strobe comes in the next cycle. Table RAM reads are registered.
//   A result is shown for one cycle with result_valid_o high; the receiver
//   cannot stall it.
//   Configuration writes (cfg_we_i, cfg_idx_i, cfg_data_i) take effect at
//   the next edge; the user must make them only while the block is idle, as
//   the block does not enforce it. Reset empties the queue, idles the back end,
//   sets the registers to their defaults; tables stay undefined until loaded.
`timescale 1ns / 1ps
`default_nettype none

module suffix_array_match_finder_top #(
  parameter int unsigned TextDepth  = samf_pkg::TextDepthDef,
  parameter int unsigned MaxRepeats = samf_pkg::MaxRepeatsDef
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic                         action_i,
  input  wire logic [samf_pkg::FieldW-1:0]  entry_addr_i,
  input  wire logic [samf_pkg::FieldW-1:0]  suffix_pos_i,
  input  wire logic [samf_pkg::FieldW-1:0]  rank_value_i,
  input  wire logic [samf_pkg::FieldW-1:0]  lcp_value_i,
  input  wire logic [samf_pkg::FieldW-1:0]  query_pos_i,
  input  wire logic                         cfg_we_i,
  input  wire logic [samf_pkg::IdxW-1:0]    cfg_idx_i,
  input  wire logic [samf_pkg::CfgW-1:0]    cfg_data_i,
  output logic                              result_valid_o,
  output logic [12:0]                       match_start_o,
  output logic [31:0]                       match_ref_o,
  output logic [11:0]                       match_length_o,
  output logic [1:0]                        match_kind_o
);
  import samf_pkg::*;

  cfg_t        cfg_q;
  item_t       item;
  queue_stat_t stat;
  logic        pop;

  assign item = '{action: action_i, entry_addr: entry_addr_i, suffix_pos: suffix_pos_i,
                  rank_value: rank_value_i, lcp_value: lcp_value_i, query_pos: query_pos_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{region_a: '0, region_b: '0, region_c: '0, mirror: '0,
                 total_len: TotalLengthRst, in_place: 1'b0};
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegRegionA:  cfg_q.region_a  <= cfg_data_i;
        RegRegionB:  cfg_q.region_b  <= cfg_data_i;
        RegRegionC:  cfg_q.region_c  <= cfg_data_i;
        RegMirror:   cfg_q.mirror    <= cfg_data_i;
        RegTotalLen: cfg_q.total_len <= cfg_data_i;
        RegInPlace:  cfg_q.in_place  <= cfg_data_i[0];
        default:     cfg_q           <= cfg_q;
      endcase
    end
  end

  samf_front u_front (
    .clk_i, .rst_ni, .start, .item_i(item), .pop_i(pop), .busy, .stat_o(stat)
  );

  samf_back #(.TextDepth(TextDepth), .MaxRepeats(MaxRepeats)) u_back (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .stat_i(stat), .pop_o(pop),
    .result_valid_o, .match_start_o, .match_ref_o, .match_length_o, .match_kind_o
  );

endmodule

`default_nettype wire
